@@ rtl/wts_pkg.sv @@
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants of the windowed time statistics block
// Field widths, register indexes, reset values and the state encodings of the
// front and back sequencers.
// ----------------------------------------------------------------------------
package wts_pkg;

  // Field widths
  localparam int RAW_W     = 32;
  localparam int WIN_W     = 16;
  localparam int LIM_W     = 15;
  localparam int SUM_W     = 36;
  localparam int SQ_W      = 51;
  localparam int SQ_OUT_W  = 50;
  localparam int CNT_OUT_W = 21;
  localparam int MEAN_W    = 16;
  localparam int SD_W      = 16;
  localparam int MILLI_W   = 43;
  localparam int SAMP_SQ_W = 2 * LIM_W;

  localparam logic [MILLI_W-1:0] MILLI_SCALE = 43'd1000;

  // Register indexes
  localparam logic [1:0] REG_WIN_LOW  = 2'd0;
  localparam logic [1:0] REG_WIN_HIGH = 2'd1;
  localparam logic [1:0] REG_MAX_ABS  = 2'd2;

  // Register reset values
  localparam logic [WIN_W-1:0] WIN_LOW_RST  = 16'h0000;
  localparam logic [WIN_W-1:0] WIN_HIGH_RST = 16'hFFFF;
  localparam logic [LIM_W-1:0] MAX_ABS_RST  = 15'h7FFF;

  // Saturation limits
  localparam logic [MEAN_W-1:0] MEAN_POS_MAX = 16'h7FFF;
  localparam logic [MEAN_W-1:0] MEAN_NEG_MIN = 16'h8000;
  localparam logic [SD_W-1:0]   SD_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_RND,
    FS_UPD
  } wts_front_state_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_SUB,
    BS_SQRT,
    BS_DIV,
    BS_DONE
  } wts_back_state_e;

  typedef struct packed {
    logic accepted;
    logic full;
  } wts_flags_t;

endpackage

@@ rtl/windowed_time_statistics.sv @@
// ----------------------------------------------------------------------------
// windowed_time_statistics: running mean and deviation of timing samples
// Each input transfer either clears the accumulators or offers a sample in
// fixed point. Kept samples update count, sum and sum of squares; every
// transfer yields one result transfer with the accumulators, mean and
// deviation as they stand after it.
// Channels: in_valid_i/in_stall_o and out_valid_o/out_stall_i; a transfer
// takes place at a clock edge with valid high and stall low. Window and limit
// registers sit on an APB-style port at byte addresses 0, 4 and 8.
// The front end steps each item through its multiply, round and update states
// and queues a snapshot in a two-entry queue. For a non-empty count the back
// end runs a bit-serial mean divide with the two products, a 36-step square
// root and a 36-step divide; for an empty count the result is valid in the
// cycle after the snapshot leaves the queue. Throughput is one item per
// back-end pass, set by the iterative unit.
// Reset clears the accumulators and loads the register defaults. While the
// receiver stalls, the result holds and the front keeps taking items until
// the queue fills.
// ----------------------------------------------------------------------------
module windowed_time_statistics import wts_pkg::*; #(
  parameter int MAX_COUNT = 1048576,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [RAW_W-1:0]     time_raw_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic                 full_res_o,
  output logic                 empty_res_o,
  output logic [CNT_OUT_W-1:0] sample_count_o,
  output logic [SUM_W-1:0]     time_sum_o,
  output logic [SQ_OUT_W-1:0]  time_sum_sq_o,
  output logic [MEAN_W-1:0]    mean_time_o,
  output logic [SD_W-1:0]      std_dev_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int QW = 2 + CW + SUM_W + SQ_W;

  logic [WIN_W-1:0] win_low_q, win_high_q;
  logic [LIM_W-1:0] max_abs_q;
  logic             cfg_wr;

  wts_flags_t       f_flags, b_flags;
  logic [CW-1:0]    f_count, b_count;
  logic [SUM_W-1:0] f_sum, b_sum;
  logic [SQ_W-1:0]  f_sq, b_sq;
  logic             push, fifo_full, pop, fifo_empty;
  logic [QW-1:0]    q_wdata, q_rdata;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= WIN_LOW_RST;
      win_high_q <= WIN_HIGH_RST;
      max_abs_q  <= MAX_ABS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIN_LOW:  win_low_q  <= pwdata[WIN_W-1:0];
        REG_WIN_HIGH: win_high_q <= pwdata[WIN_W-1:0];
        REG_MAX_ABS:  max_abs_q  <= pwdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      REG_WIN_LOW:  prdata = {16'h0000, win_low_q};
      REG_WIN_HIGH: prdata = {16'h0000, win_high_q};
      REG_MAX_ABS:  prdata = {17'h00000, max_abs_q};
      default:      prdata = '0;
    endcase
  end

  wts_front #(
    .MAX_COUNT (MAX_COUNT),
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .time_raw_i   (time_raw_i),
    .win_low_i    (win_low_q),
    .win_high_i   (win_high_q),
    .max_abs_i    (max_abs_q),
    .push_o       (push),
    .push_stall_i (fifo_full),
    .flags_o      (f_flags),
    .count_o      (f_count),
    .sum_o        (f_sum),
    .sum_sq_o     (f_sq)
  );

  assign q_wdata = {f_flags, f_count, f_sum, f_sq};
  assign {b_flags, b_count, b_sum, b_sq} = q_rdata;

  wts_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (fifo_empty)
  );

  wts_back #(
    .CW (CW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (fifo_empty),
    .pop_o          (pop),
    .flags_i        (b_flags),
    .count_i        (b_count),
    .sum_i          (b_sum),
    .sum_sq_i       (b_sq),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .full_res_o     (full_res_o),
    .empty_res_o    (empty_res_o),
    .sample_count_o (sample_count_o),
    .time_sum_o     (time_sum_o),
    .time_sum_sq_o  (time_sum_sq_o),
    .mean_time_o    (mean_time_o),
    .std_dev_o      (std_dev_o)
  );

endmodule

@@ rtl/wts_fifo.sv @@
// ----------------------------------------------------------------------------
// wts_fifo: two-entry snapshot queue
// Decouples the accumulator front end from the iterative statistics back end.
// ----------------------------------------------------------------------------
module wts_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !full_o) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i && !full_o, pop_i && !empty_o})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store an entry on push
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/wts_front.sv @@
// ----------------------------------------------------------------------------
// wts_front: sample conversion, classification and accumulation
// Scales a sample to milli-units with round-half-to-even, checks limit and
// window, updates count, sum and sum of squares and queues a snapshot.
// ----------------------------------------------------------------------------
module wts_front import wts_pkg::*; #(
  parameter int MAX_COUNT = 1048576,
  parameter int FRAC_BITS = 16,
  parameter int CW        = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [RAW_W-1:0] time_raw_i,
  input  logic [WIN_W-1:0] win_low_i,
  input  logic [WIN_W-1:0] win_high_i,
  input  logic [LIM_W-1:0] max_abs_i,
  output logic             push_o,
  input  logic             push_stall_i,
  output wts_flags_t       flags_o,
  output logic [CW-1:0]    count_o,
  output logic [SUM_W-1:0] sum_o,
  output logic [SQ_W-1:0]  sum_sq_o
);

  localparam logic [MILLI_W-1:0] FRAC_MASK = (43'd1 << FRAC_BITS) - 43'd1;
  localparam logic [MILLI_W-1:0] FRAC_HALF = (43'd1 << FRAC_BITS) >> 1;
  localparam logic               RND_EN    = (FRAC_BITS > 0);
  localparam logic [CW-1:0]      CNT_CAP   = CW'(MAX_COUNT);

  wts_front_state_e state_q, state_d;

  logic               clr_q;
  logic [RAW_W-1:0]   raw_q;
  logic [MILLI_W-1:0] prod_q, prod_d;
  logic               neg_q, neg_d;
  logic [MILLI_W-1:0] mag_q, mag_d;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]    sq_q, sq_d;
  wts_flags_t         flags_d;

  logic [MILLI_W-1:0]     abs_p, quo, rem;
  logic                   rnd_up;
  logic signed [MILLI_W:0] m_s, lo_s, hi_s;
  logic                   win_en, keep;
  logic [SAMP_SQ_W-1:0]   samp_sq;
  logic [SUM_W-1:0]       samp_sum;

  // Scale to milli-units
  assign prod_d = $signed({{(MILLI_W-RAW_W){raw_q[RAW_W-1]}}, raw_q}) * $signed(MILLI_SCALE);

  // Round magnitude, ties to even
  always_comb begin
    abs_p  = prod_q[MILLI_W-1] ? (~prod_q + 43'd1) : prod_q;
    quo    = abs_p >> FRAC_BITS;
    rem    = abs_p & FRAC_MASK;
    rnd_up = RND_EN && ((rem > FRAC_HALF) || ((rem == FRAC_HALF) && quo[0]));
    neg_d  = prod_q[MILLI_W-1];
    mag_d  = quo + {{(MILLI_W-1){1'b0}}, rnd_up};
  end

  // Classify and compute updated accumulators
  always_comb begin
    m_s      = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    lo_s     = (MILLI_W+1)'($signed(win_low_i));
    hi_s     = (MILLI_W+1)'($signed(win_high_i));
    win_en   = (hi_s >= lo_s);
    keep     = (mag_q <= MILLI_W'(max_abs_i)) && !(win_en && ((m_s < lo_s) || (m_s > hi_s)));
    samp_sq  = mag_q[LIM_W-1:0] * mag_q[LIM_W-1:0];
    samp_sum = neg_q ? (~SUM_W'(mag_q[LIM_W-1:0]) + 36'd1) : SUM_W'(mag_q[LIM_W-1:0]);
    flags_d  = '0;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    if (clr_q) begin
      cnt_d = '0;
      sum_d = '0;
      sq_d  = '0;
    end else if (keep) begin
      if (cnt_q >= CNT_CAP) begin
        flags_d.full = 1'b1;
      end else begin
        flags_d.accepted = 1'b1;
        cnt_d = cnt_q + CW'(1);
        sum_d = sum_q + samp_sum;
        sq_d  = sq_q + SQ_W'(samp_sq);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != FS_IDLE);
    push_o     = 1'b0;
    case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          state_d = FS_MUL;
        end
      end
      FS_MUL: state_d = FS_RND;
      FS_RND: state_d = FS_UPD;
      FS_UPD: begin
        if (!push_stall_i) begin
          push_o  = 1'b1;
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  assign flags_o  = flags_d;
  assign count_o  = cnt_d;
  assign sum_o    = sum_d;
  assign sum_sq_o = sq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      state_q <= state_d;
      if (push_o) begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        sq_q  <= sq_d;
      end
    end
  end

  // Hold the item through its stages
  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && in_valid_i) begin
      clr_q <= req_type_i;
      raw_q <= time_raw_i;
    end
    if (state_q == FS_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == FS_RND) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
  end

endmodule

@@ rtl/wts_back.sv @@
// ----------------------------------------------------------------------------
// wts_back: iterative mean and deviation unit
// Takes a snapshot, runs a bit-serial divide for the mean alongside two
// shift-add products, a digit-by-digit square root and a final divide.
// ----------------------------------------------------------------------------
module wts_back import wts_pkg::*; #(
  parameter int CW = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  output logic                pop_o,
  input  wts_flags_t          flags_i,
  input  logic [CW-1:0]       count_i,
  input  logic [SUM_W-1:0]    sum_i,
  input  logic [SQ_W-1:0]     sum_sq_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                accepted_o,
  output logic                full_res_o,
  output logic                empty_res_o,
  output logic [CNT_OUT_W-1:0] sample_count_o,
  output logic [SUM_W-1:0]    time_sum_o,
  output logic [SQ_OUT_W-1:0] time_sum_sq_o,
  output logic [MEAN_W-1:0]   mean_time_o,
  output logic [SD_W-1:0]     std_dev_o
);

  localparam int VW0 = (CW + SQ_W > 2 * SUM_W - 2) ? CW + SQ_W : 2 * SUM_W - 2;
  localparam int VW  = VW0 + (VW0 % 2);
  localparam int RW  = VW / 2;
  localparam int DW  = (RW > SUM_W) ? RW : SUM_W;
  localparam int SW  = $clog2(DW);

  wts_back_state_e state_q, state_d;

  logic [DW-1:0]    dvd_q, dvd_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    cnt_q;
  logic [DW-1:0]    csh_q;
  logic [SUM_W-1:0] smag_q;
  logic             neg_q;
  logic [SQ_W-1:0]  sq_q;
  logic [VW-1:0]    acc_a_q, acc_b_q;
  logic [VW-1:0]    rad_q;
  logic [RW:0]      srem_q, srem_d;
  logic [RW-1:0]    root_q, root_d;
  logic [SW-1:0]    step_q;

  logic [CW:0]      dtrial;
  logic             dge;
  logic [RW+2:0]    strial, stest;
  logic             sge;
  logic [SUM_W-1:0] sum_abs;

  // Restoring divide step, shared by mean and deviation
  always_comb begin
    dtrial = {rem_q, dvd_q[DW-1]};
    dge    = (dtrial >= {1'b0, cnt_q});
    rem_d  = dge ? CW'(dtrial - {1'b0, cnt_q}) : dtrial[CW-1:0];
    dvd_d  = {dvd_q[DW-2:0], dge};
  end

  // Square-root digit step
  always_comb begin
    strial = {srem_q, rad_q[VW-1:VW-2]};
    stest  = {1'b0, root_q, 2'b01};
    sge    = (strial >= stest);
    srem_d = sge ? (RW+1)'(strial - stest) : strial[RW:0];
    root_d = {root_q[RW-2:0], sge};
  end

  assign sum_abs = sum_i[SUM_W-1] ? (~sum_i + 36'd1) : sum_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          state_d = (count_i == '0) ? BS_DONE : BS_MUL;
        end
      end
      BS_MUL:  if (step_q == '0) state_d = BS_SUB;
      BS_SUB:  state_d = BS_SQRT;
      BS_SQRT: if (step_q == '0) state_d = BS_DIV;
      BS_DIV:  if (step_q == '0) state_d = BS_DONE;
      BS_DONE: if (!out_stall_i) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == BS_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        if (pop_o) begin
          accepted_o     <= flags_i.accepted;
          full_res_o     <= flags_i.full;
          empty_res_o    <= (count_i == '0);
          sample_count_o <= CNT_OUT_W'(count_i);
          time_sum_o     <= sum_i;
          time_sum_sq_o  <= sum_sq_i[SQ_OUT_W-1:0];
          mean_time_o    <= '0;
          std_dev_o      <= '0;
          cnt_q          <= count_i;
          csh_q          <= DW'(count_i);
          smag_q         <= sum_abs;
          neg_q          <= sum_i[SUM_W-1];
          sq_q           <= sum_sq_i;
          dvd_q          <= DW'(sum_abs);
          rem_q          <= '0;
          acc_a_q        <= '0;
          acc_b_q        <= '0;
          step_q         <= SW'(DW - 1);
        end
      end
      BS_MUL: begin
        // divide |sum| by count while forming count*sumsq and sum^2
        dvd_q   <= dvd_d;
        rem_q   <= rem_d;
        csh_q   <= {csh_q[DW-2:0], 1'b0};
        acc_a_q <= {acc_a_q[VW-2:0], 1'b0} + (csh_q[DW-1] ? VW'(sq_q) : '0);
        acc_b_q <= {acc_b_q[VW-2:0], 1'b0} + (dvd_q[DW-1] ? VW'(smag_q) : '0);
        step_q  <= step_q - SW'(1);
        if (step_q == '0) begin
          if (neg_q) begin
            mean_time_o <= (dvd_d > DW'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN :
                           (~dvd_d[MEAN_W-1:0] + 16'd1);
          end else begin
            mean_time_o <= (dvd_d > DW'(MEAN_POS_MAX)) ? MEAN_POS_MAX : dvd_d[MEAN_W-1:0];
          end
        end
      end
      BS_SUB: begin
        // clamp a negative numerator to zero
        rad_q  <= (acc_a_q >= acc_b_q) ? (acc_a_q - acc_b_q) : '0;
        srem_q <= '0;
        root_q <= '0;
        step_q <= SW'(RW - 1);
      end
      BS_SQRT: begin
        srem_q <= srem_d;
        root_q <= root_d;
        rad_q  <= {rad_q[VW-3:0], 2'b00};
        if (step_q == '0) begin
          dvd_q  <= DW'(root_d);
          rem_q  <= '0;
          step_q <= SW'(DW - 1);
        end else begin
          step_q <= step_q - SW'(1);
        end
      end
      BS_DIV: begin
        dvd_q  <= dvd_d;
        rem_q  <= rem_d;
        step_q <= step_q - SW'(1);
        if (step_q == '0) begin
          std_dev_o <= (dvd_d > DW'(SD_MAX)) ? SD_MAX : dvd_d[SD_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ bench/tb_windowed_time_statistics.sv @@
// ----------------------------------------------------------------------------
// tb_windowed_time_statistics: self-checking bench for the timing statistics
// Drives clears and fixed-point samples through the valid/stall channel,
// predicts every result transfer from a behavioural model of rounding, limit,
// window and accumulation, and compares each field. Registers are written
// over the APB-style port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_windowed_time_statistics;
  import wts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic                 accepted;
    logic                 full;
    logic                 empty;
    logic [CNT_OUT_W-1:0] count;
    logic [SUM_W-1:0]     sum;
    logic [SQ_OUT_W-1:0]  sum_sq;
    logic [MEAN_W-1:0]    mean;
    logic [SD_W-1:0]      sd;
  } stats_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [RAW_W-1:0] time_raw_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accepted_o, full_res_o, empty_res_o;
  logic [CNT_OUT_W-1:0] sample_count_o;
  logic [SUM_W-1:0] time_sum_o;
  logic [SQ_OUT_W-1:0] time_sum_sq_o;
  logic [MEAN_W-1:0] mean_time_o;
  logic [SD_W-1:0] std_dev_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  windowed_time_statistics u_top (.*);

  // Model state
  logic signed [WIN_W-1:0] win_low_q;
  logic signed [WIN_W-1:0] win_high_q;
  logic [LIM_W-1:0] max_abs_q;
  int unsigned count_q;
  logic [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0] sum_sq_q;

  stats_result_t expected_stats[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned kept = 0;
  int unsigned idle_cycles = 0;
  bit long_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  // Convert a raw sample to milli-units, ties to even on the magnitude
  function automatic longint to_millis(logic [RAW_W-1:0] raw);
    longint p, q, rem, half;
    logic [63:0] mag;
    p = longint'($signed(raw)) * 1000;
    mag = (p < 0) ? -p : p;
    q = mag >> 16;
    rem = mag & 64'hFFFF;
    half = 64'h8000;
    if (rem > half || (rem == half && q[0])) q++;
    return (p < 0) ? -q : q;
  endfunction

  // Square root of a wide value, bit by bit
  function automatic logic [63:0] wide_sqrt(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // Apply one item to the model and queue the expected result
  task automatic predict_stats(input logic clear, input logic [RAW_W-1:0] raw);
    stats_result_t r;
    longint m, s, mean;
    logic [63:0] mag, smag, sd;
    logic [127:0] a, b, v;
    bit keep;
    r = '{default: '0};
    if (clear) begin
      count_q = 0;
      sum_q = '0;
      sum_sq_q = '0;
    end else begin
      m = to_millis(raw);
      mag = (m < 0) ? -m : m;
      keep = mag <= max_abs_q;
      if (win_high_q >= win_low_q && (m < win_low_q || m > win_high_q)) keep = 0;
      if (keep) begin
        if (count_q >= 1048576) r.full = 1'b1;
        else begin
          count_q++;
          sum_q = sum_q + m[SUM_W-1:0];
          sum_sq_q = sum_sq_q + SQ_W'(mag * mag);
          r.accepted = 1'b1;
          kept++;
        end
      end
    end
    if (count_q == 0) r.empty = 1'b1;
    else begin
      s = longint'($signed(sum_q));
      mean = s / longint'(count_q);
      if (mean > 32767) mean = 32767;
      if (mean < -32768) mean = -32768;
      r.mean = mean[MEAN_W-1:0];
      smag = (s < 0) ? -s : s;
      a = 128'(count_q) * 128'(sum_sq_q);
      b = 128'(smag) * 128'(smag);
      v = (b <= a) ? a - b : '0;
      sd = wide_sqrt(v) / 64'(count_q);
      r.sd = (sd > 65535) ? 16'hFFFF : sd[SD_W-1:0];
    end
    r.count = count_q[CNT_OUT_W-1:0];
    r.sum = sum_q;
    r.sum_sq = sum_sq_q[SQ_OUT_W-1:0];
    expected_stats.insert(expected_stats.size(), r);
  endtask

  // Offer one transfer after a random gap and hold it until taken
  task automatic send_sample(input logic clear, input logic [RAW_W-1:0] raw,
                             input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // drop valid only across a real gap
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= clear;
    time_raw_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_stats(clear, raw);
    sent++;
    @(negedge clk_i);
  endtask

  // Write one register over the APB port
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIN_LOW:  win_low_q  = value[WIN_W-1:0];
      REG_WIN_HIGH: win_high_q = value[WIN_W-1:0];
      REG_MAX_ABS:  max_abs_q  = value[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // Stop offering, wait for all results, then let the back end settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_window(input int lo, input int hi, input int lim);
    drain();
    write_reg(REG_WIN_LOW, lo);
    write_reg(REG_WIN_HIGH, hi);
    write_reg(REG_MAX_ABS, lim);
  endtask

  // Raw value of a milli-unit amount, optionally with an offset in raw units
  function automatic logic [RAW_W-1:0] raw_of(int milli, int frac_adj);
    return RAW_W'((longint'(milli) * 65536) / 1000 + frac_adj);
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return RAW_W'($signed($urandom_range(0, 4000)) - 2000);
      default: return raw_of(int'($urandom_range(0, 70000)) - 35000,
                             int'($urandom_range(0, 130)) - 65);
    endcase
  endfunction

  // Receiver stall: a random hold before each result, stretched for as long
  // as a long hold is requested
  always begin
    int hold_n;
    hold_n = $urandom_range(0, 10);
    if (hold_n != 0 || long_hold) begin
      out_stall_i <= 1'b1;
      repeat (hold_n) @(negedge clk_i);
      while (long_hold) @(negedge clk_i);
    end
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!out_valid_o);
    @(negedge clk_i);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    stats_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked++;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, count %0d", $time, sample_count_o);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if ({accepted_o, full_res_o, empty_res_o} != {e.accepted, e.full, e.empty}) begin
          $display("%0t: flags exp %b%b%b got %b%b%b", $time, e.accepted, e.full,
                   e.empty, accepted_o, full_res_o, empty_res_o);
          errors++;
        end
        if (sample_count_o != e.count) begin
          $display("%0t: count exp %0d got %0d", $time, e.count, sample_count_o);
          errors++;
        end
        if (time_sum_o != e.sum) begin
          $display("%0t: sum exp %h got %h", $time, e.sum, time_sum_o);
          errors++;
        end
        if (time_sum_sq_o != e.sum_sq) begin
          $display("%0t: sum_sq exp %h got %h", $time, e.sum_sq, time_sum_sq_o);
          errors++;
        end
        if (mean_time_o != e.mean) begin
          $display("%0t: mean exp %h got %h", $time, e.mean, mean_time_o);
          errors++;
        end
        if (std_dev_o != e.sd) begin
          $display("%0t: std_dev exp %h got %h", $time, e.sd, std_dev_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("windowed_time_statistics verification failed");
      $finish;
    end
  end

  // Extremes, rounding ties, empty and clear cases
  task automatic test_directed();
    send_sample(1'b1, 32'h0);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'h0);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd65536);
    send_sample(1'b0, -32'sd65536);
    send_sample(1'b0, 32'h0000_0020);   // just below a half milli-unit
    send_sample(1'b0, 32'h0000_00C5);   // rounds to three
    send_sample(1'b0, raw_of(32767, 0));
    send_sample(1'b0, raw_of(-32767, 0));
    send_sample(1'b0, raw_of(32768, 0));
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, raw_of(1500, 0));
    send_sample(1'b0, raw_of(-2500, 0));
    // exact half-unit ties: raw*1000 = k*65536 + 32768
    send_sample(1'b0, 32'd4096);
    send_sample(1'b0, 32'd12288);
    send_sample(1'b0, -32'sd4096);
    send_sample(1'b0, -32'sd12288);
  endtask

  // Window and limit settings with random samples and occasional clears
  task automatic test_window_phase(input int lo, input int hi, input int lim, input int n);
    set_window(lo, hi, lim);
    send_sample(1'b1, $urandom());
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 40) == 0) send_sample(1'b1, $urandom());
      else send_sample(1'b0, rand_raw());
  endtask

  // Hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_sample(1'b0, rand_raw(), 1);
    join
    drain();
  endtask

  initial begin
    win_low_q = WIN_LOW_RST;
    win_high_q = WIN_HIGH_RST;
    max_abs_q = MAX_ABS_RST;
    count_q = 0;
    sum_q = '0;
    sum_sq_q = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_window_phase(-32768, 32767, 32767, 250);
    test_window_phase(-1000, 1000, 32767, 250);
    test_window_phase(0, -1, 0, 100);
    test_window_phase(32767, -32768, 20000, 250);
    test_backpressure();
    test_window_phase(-32768, -32768, 32767, 100);
    test_window_phase(32767, 32767, 32767, 100);
    test_window_phase(500, 400, 3000, 200);
    test_window_phase(-5000, 20000, 32767, 200);

    drain();
    $display("Sent %0d transfers (%0d samples kept), checked %0d results,",
             sent, kept, checked);
    $display("over nine window and limit settings with clears and long stalls.");
    if (errors == 0 && expected_stats.size() == 0)
      $display("windowed_time_statistics verification clean");
    else
      $display("windowed_time_statistics verification failed");
    $finish;
  end

endmodule

@@ windowed_time_statistics.f @@
rtl/wts_pkg.sv
rtl/wts_fifo.sv
rtl/wts_front.sv
rtl/wts_back.sv
rtl/windowed_time_statistics.sv
bench/tb_windowed_time_statistics.sv
